// File: rtl/mi3_pkg.sv
// shared widths, types and helpers for the 3x3 matrix inverse pipeline
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // element product, cofactor, cofactor half, determinant, scaled numerator, remainder widths
  localparam int PW  = 2 * DATA_WIDTH;
  localparam int CW  = PW + 1;
  localparam int HW  = DATA_WIDTH + 1;
  localparam int DTW = DATA_WIDTH + CW + 2;
  localparam int NTW = CW + 2 * FRAC_BITS;
  localparam int RW  = DTW + 1;

  localparam int NUM_ELEM = 9;
  localparam int NUM_COF  = 9;

  // cofactor k = a[x] * a[y] - a[z] * a[w], in transposed (adjugate) order
  localparam logic [3:0] COF_IDX [NUM_COF][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd7, 4'd2, 4'd8, 4'd1},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd8, 4'd0, 4'd6, 4'd2},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd6, 4'd1, 4'd7, 4'd0},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  localparam logic [DTW-1:0]        SAT_LIM = DTW'(1) << (DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic [RW-1:0]         rem;
    logic [DATA_WIDTH-1:0] nq;
    logic                  ovf;
    logic                  neg;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    lane_t [NUM_COF-1:0]   lane;
    logic [DTW-1:0]        dmag;
    logic                  sing;
    logic [DATA_WIDTH-1:0] det_out;
  } div_stage_t;

  // sign and magnitude to a saturated two's complement result
  function automatic logic [DATA_WIDTH-1:0] sat_mag(input logic neg,
                                                    input logic [DTW-1:0] mag);
    logic [DTW-1:0]        t;
    logic [DATA_WIDTH-1:0] res;
    t = ~mag + DTW'(1);
    if (neg) begin
      if (mag > SAT_LIM) res = MIN_VAL;
      else               res = t[DATA_WIDTH-1:0];
    end else begin
      if (mag >= SAT_LIM) res = MAX_VAL;
      else                res = mag[DATA_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/mi3_div_step.sv
// one restoring division step for all nine lanes, registered
module mi3_div_step (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  mi3_pkg::div_stage_t     d_in,
  output mi3_pkg::div_stage_t     d_out
);

  mi3_pkg::div_stage_t d_nxt;
  mi3_pkg::div_stage_t d_r;

  always_comb begin
    logic [mi3_pkg::RW-1:0] sh;
    logic [mi3_pkg::RW-1:0] dv;
    d_nxt = d_in;
    dv = mi3_pkg::RW'(d_in.dmag);
    for (int k = 0; k < mi3_pkg::NUM_COF; k++) begin
      sh = {d_in.lane[k].rem[mi3_pkg::RW-2:0], d_in.lane[k].nq[mi3_pkg::DATA_WIDTH-1]};
      if (sh >= dv) begin
        d_nxt.lane[k].rem = sh - dv;
        d_nxt.lane[k].nq  = {d_in.lane[k].nq[mi3_pkg::DATA_WIDTH-2:0], 1'b1};
      end else begin
        d_nxt.lane[k].rem = sh;
        d_nxt.lane[k].nq  = {d_in.lane[k].nq[mi3_pkg::DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  // valid bit resets, data registers carry no reset
  always_ff @(posedge clk) begin
    if (en) begin
      d_r.lane    <= d_nxt.lane;
      d_r.dmag    <= d_nxt.dmag;
      d_r.sing    <= d_nxt.sing;
      d_r.det_out <= d_nxt.det_out;
    end
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_in.valid;
    end
  end

  assign d_out = d_r;

endmodule

// File: rtl/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by adjugate, fully pipelined
//
//  channel  | ports                               | direction
//  ---------+-------------------------------------+-----------
//  input    | in_valid, in_stall, in_a00..in_a22  | item in
//  result   | out_valid, out_stall, out_b00..b22, | item out
//           | out_determinant, out_singular       |
//
// one item enters per cycle when not stalled; stages: products, cofactors, partials,
// determinant, magnitudes, setup, restoring divider at one bit per lane per stage
// the whole pipeline advances together; out_stall with a waiting result freezes
// every stage and raises in_stall, so nothing is dropped or repeated
// rst_n clears the valid bits only; data registers carry no reset
module matrix_inverse_3x3 (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a00,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a01,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a02,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a10,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a11,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a12,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a20,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a21,
  input  logic signed [mi3_pkg::DATA_WIDTH-1:0] in_a22,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b00,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b01,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b02,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b10,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b11,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b12,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b20,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b21,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_b22,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] out_determinant,
  output logic                                  out_singular
);

  localparam int DW = mi3_pkg::DATA_WIDTH;
  localparam int FB = mi3_pkg::FRAC_BITS;

  // global advance: hold everything while a finished item is refused
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic signed [DW-1:0] a [mi3_pkg::NUM_ELEM];
  assign a[0] = in_a00;
  assign a[1] = in_a01;
  assign a[2] = in_a02;
  assign a[3] = in_a10;
  assign a[4] = in_a11;
  assign a[5] = in_a12;
  assign a[6] = in_a20;
  assign a[7] = in_a21;
  assign a[8] = in_a22;

  // stage 1: the eighteen element products
  logic                         v1_r;
  logic signed [mi3_pkg::PW-1:0] prod_r [2 * mi3_pkg::NUM_COF];
  logic signed [DW-1:0]          top1_r [3];

  // stage 2: cofactors
  logic                          v2_r;
  logic signed [mi3_pkg::CW-1:0] cof2_r [mi3_pkg::NUM_COF];
  logic signed [DW-1:0]          top2_r [3];

  // stage 3: split partial products of the first-row expansion
  logic                          v3_r;
  logic signed [mi3_pkg::CW-1:0] cof3_r [mi3_pkg::NUM_COF];
  logic signed [2*DW:0]          plo_r  [3];
  logic signed [2*DW:0]          phi_r  [3];

  // stage 4: exact determinant
  logic                           v4_r;
  logic signed [mi3_pkg::CW-1:0]  cof4_r [mi3_pkg::NUM_COF];
  logic signed [mi3_pkg::DTW-1:0] det_r;

  // stage 5: signs and magnitudes
  logic                           v5_r;
  logic [mi3_pkg::CW-1:0]         cmag_r [mi3_pkg::NUM_COF];
  logic                           cneg_r [mi3_pkg::NUM_COF];
  logic [mi3_pkg::DTW-1:0]        dmag_r;
  logic                           dneg_r;
  logic                           sing_r;

  // stage 6: divider setup, then one stage per quotient bit
  mi3_pkg::div_stage_t s6_r;
  mi3_pkg::div_stage_t chain [DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1 and 2
  for (genvar k = 0; k < mi3_pkg::NUM_COF; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[2*k]   <= mi3_pkg::PW'(a[mi3_pkg::COF_IDX[k][0]])
                       * mi3_pkg::PW'(a[mi3_pkg::COF_IDX[k][1]]);
        prod_r[2*k+1] <= mi3_pkg::PW'(a[mi3_pkg::COF_IDX[k][2]])
                       * mi3_pkg::PW'(a[mi3_pkg::COF_IDX[k][3]]);
        cof2_r[k] <= mi3_pkg::CW'(prod_r[2*k]) - mi3_pkg::CW'(prod_r[2*k+1]);
        cof3_r[k] <= cof2_r[k];
        cof4_r[k] <= cof3_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top1_r[0] <= a[0];
      top1_r[1] <= a[1];
      top1_r[2] <= a[2];
      top2_r    <= top1_r;
    end
  end

  // stage 3: det = a00*cof0 + a01*cof3 + a02*cof6, each cofactor cut in two halves
  for (genvar j = 0; j < 3; j++) begin : g_det
    localparam int HWL = mi3_pkg::HW;
    logic signed [HWL-1:0] lo_s;
    logic signed [HWL-1:0] hi_s;
    assign lo_s = $signed({1'b0, cof2_r[3*j][DW-1:0]});
    assign hi_s = $signed(cof2_r[3*j][mi3_pkg::CW-1:DW]);
    always_ff @(posedge clk) begin
      if (en) begin
        plo_r[j] <= (2*DW+1)'(top2_r[j]) * (2*DW+1)'(lo_s);
        phi_r[j] <= (2*DW+1)'(top2_r[j]) * (2*DW+1)'(hi_s);
      end
    end
  end

  // stage 4: recombine halves and sum the three terms
  logic signed [mi3_pkg::DTW-1:0] term [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term[j] = (mi3_pkg::DTW'(phi_r[j]) <<< DW) + mi3_pkg::DTW'(plo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= term[0] + term[1] + term[2];
    end
  end

  // stage 5: magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r <= det_r[mi3_pkg::DTW-1];
      dmag_r <= det_r[mi3_pkg::DTW-1] ? mi3_pkg::DTW'(-det_r) : mi3_pkg::DTW'(det_r);
      sing_r <= (det_r == '0);
      for (int k = 0; k < mi3_pkg::NUM_COF; k++) begin
        cneg_r[k] <= cof4_r[k][mi3_pkg::CW-1];
        cmag_r[k] <= cof4_r[k][mi3_pkg::CW-1] ? mi3_pkg::CW'(-cof4_r[k])
                                               : mi3_pkg::CW'(cof4_r[k]);
      end
    end
  end

  // stage 6: numerator is |cof| scaled by 2^(2*FRAC_BITS); a quotient that
  // cannot fit in DATA_WIDTH bits is flagged up front and saturated at the end
  always_ff @(posedge clk) begin
    logic [mi3_pkg::NTW-1:0] num;
    logic [mi3_pkg::RW-1:0]  rem0;
    if (en) begin
      for (int k = 0; k < mi3_pkg::NUM_COF; k++) begin
        num  = {cmag_r[k], {(2*FB){1'b0}}};
        rem0 = mi3_pkg::RW'(num >> DW);
        s6_r.lane[k].rem <= rem0;
        s6_r.lane[k].nq  <= num[DW-1:0];
        s6_r.lane[k].ovf <= (rem0 >= mi3_pkg::RW'(dmag_r));
        s6_r.lane[k].neg <= cneg_r[k] ^ dneg_r;
      end
      s6_r.dmag    <= dmag_r;
      s6_r.sing    <= sing_r;
      // determinant has 3*FRAC_BITS fraction bits: drop 2*FRAC_BITS toward zero
      s6_r.det_out <= mi3_pkg::sat_mag(dneg_r, dmag_r >> (2*FB));
    end
    if (!rst_n) begin
      s6_r.valid <= 1'b0;
    end else if (en) begin
      s6_r.valid <= v5_r;
    end
  end

  assign chain[0] = s6_r;

  for (genvar s = 0; s < DW; s++) begin : g_div
    mi3_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[s]),
      .d_out (chain[s+1])
    );
  end

  // output register: sign, saturation and the singular override
  mi3_pkg::div_stage_t last;
  assign last = chain[DW];

  logic [DW-1:0] b_nxt [mi3_pkg::NUM_COF];
  logic [DW-1:0] b_r   [mi3_pkg::NUM_COF];
  logic [DW-1:0] det_out_r;
  logic          sing_out_r;

  always_comb begin
    for (int k = 0; k < mi3_pkg::NUM_COF; k++) begin
      if (last.sing) begin
        b_nxt[k] = '0;
      end else if (last.lane[k].ovf) begin
        b_nxt[k] = mi3_pkg::sat_mag(last.lane[k].neg, '1);
      end else begin
        b_nxt[k] = mi3_pkg::sat_mag(last.lane[k].neg, mi3_pkg::DTW'(last.lane[k].nq));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r        <= b_nxt;
      det_out_r  <= last.det_out;
      sing_out_r <= last.sing;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_b00         = $signed(b_r[0]);
  assign out_b01         = $signed(b_r[1]);
  assign out_b02         = $signed(b_r[2]);
  assign out_b10         = $signed(b_r[3]);
  assign out_b11         = $signed(b_r[4]);
  assign out_b12         = $signed(b_r[5]);
  assign out_b20         = $signed(b_r[6]);
  assign out_b21         = $signed(b_r[7]);
  assign out_b22         = $signed(b_r[8]);
  assign out_determinant = $signed(det_out_r);
  assign out_singular    = sing_out_r;

endmodule

// File: tb/testbench.sv
// self-checking testbench for the 3x3 fixed-point matrix inverse pipeline
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH = mi3_pkg::DATA_WIDTH;
  localparam int FRAC_BITS  = mi3_pkg::FRAC_BITS;

  localparam int LATENCY   = 6 + DATA_WIDTH + 1;
  localparam int N_RANDOM  = 1950;
  localparam int QUIET_LEN = 150;   // final stretch with no idling on either side

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  typedef struct {
    elem_t m [9];
  } matrix_t;

  typedef struct {
    elem_t inv [9];
    elem_t det;
    logic  sing;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic  in_valid = 1'b0;
  logic  in_stall;
  elem_t in_a [9] = '{default: '0};
  logic  out_valid;
  logic  out_stall = 1'b0;
  elem_t out_b [9];
  elem_t out_determinant;
  logic  out_singular;

  matrix_t  pending_matrices [$];
  inverse_t expected_inverses [$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_singular = 0;
  int n_saturated = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;      // long receiver stall forced by its own process
  bit quiet = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  matrix_inverse_3x3 DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_b00(out_b[0]), .out_b01(out_b[1]), .out_b02(out_b[2]),
    .out_b10(out_b[3]), .out_b11(out_b[4]), .out_b12(out_b[5]),
    .out_b20(out_b[6]), .out_b21(out_b[7]), .out_b22(out_b[8]),
    .out_determinant(out_determinant), .out_singular(out_singular)
  );

  // wide signed arithmetic: products are 64 bits, the determinant needs ~98,
  // cofactor << 2*FRAC_BITS needs ~97; 200 bits is plenty
  typedef logic signed [199:0] wide_t;

  function automatic elem_t saturate(input wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -(wide_t'(1) <<< (DATA_WIDTH - 1));
    if (v > hi) return elem_t'(hi);
    if (v < lo) return elem_t'(lo);
    return elem_t'(v);
  endfunction

  // magnitude division truncates toward zero, as the block must
  function automatic wide_t div_trunc(input wide_t n, input wide_t d);
    wide_t un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // cofactor table in adjugate output order: x*y - z*w
  function automatic inverse_t invert_matrix(input matrix_t a);
    inverse_t r;
    wide_t e [9];
    wide_t cof [9];
    wide_t det;
    int idx [9][4];
    idx = '{'{4,8,5,7}, '{7,2,8,1}, '{1,5,2,4}, '{5,6,3,8}, '{8,0,6,2},
            '{2,3,0,5}, '{3,7,4,6}, '{6,1,7,0}, '{0,4,1,3}};
    for (int k = 0; k < 9; k++) e[k] = wide_t'(a.m[k]);
    for (int k = 0; k < 9; k++)
      cof[k] = e[idx[k][0]] * e[idx[k][1]] - e[idx[k][2]] * e[idx[k][3]];
    det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    if (det == 0) begin
      for (int k = 0; k < 9; k++) r.inv[k] = '0;
      r.det = '0;
      r.sing = 1'b1;
    end else begin
      for (int k = 0; k < 9; k++)
        r.inv[k] = saturate(div_trunc(cof[k] <<< (2 * FRAC_BITS), det));
      r.det = saturate(div_trunc(det, wide_t'(1) <<< (2 * FRAC_BITS)));
      r.sing = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input elem_t got, input elem_t want);
    errors++;
    $display("mismatch on result %0d, %s: got %h expected %h", n_checked, what, got, want);
  endtask

  function automatic elem_t random_elem();
    case ($urandom_range(0, 9))
      0: return elem_t'({1'b1, {(DATA_WIDTH - 1){1'b0}}});
      1: return elem_t'({1'b0, {(DATA_WIDTH - 1){1'b1}}});
      2: return elem_t'($urandom_range(0, 5)) <<< FRAC_BITS;
      3: return -(elem_t'($urandom_range(0, 5)) <<< FRAC_BITS);
      4: return elem_t'($signed($urandom_range(0, 8)) - 4);   // tiny values
      5: return '0;
      6: return elem_t'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19); // near one
      default: return elem_t'($urandom);
    endcase
  endfunction

  // fill the item queue: directed corners first, then random matrices
  initial begin
    matrix_t mx;
    elem_t one, maxv, minv;
    one = elem_t'(1) <<< FRAC_BITS;
    maxv = elem_t'({1'b0, {(DATA_WIDTH - 1){1'b1}}});
    minv = elem_t'({1'b1, {(DATA_WIDTH - 1){1'b0}}});
    // identity
    foreach (mx.m[k]) mx.m[k] = (k % 4 == 0) ? one : '0;
    pending_matrices.push_back(mx);
    // all zero, singular
    foreach (mx.m[k]) mx.m[k] = '0;
    pending_matrices.push_back(mx);
    // all max, all min: rank one, singular
    foreach (mx.m[k]) mx.m[k] = maxv;
    pending_matrices.push_back(mx);
    foreach (mx.m[k]) mx.m[k] = minv;
    pending_matrices.push_back(mx);
    // diagonal extremes, determinant overflows
    foreach (mx.m[k]) mx.m[k] = (k % 4 == 0) ? maxv : '0;
    pending_matrices.push_back(mx);
    foreach (mx.m[k]) mx.m[k] = (k % 4 == 0) ? minv : '0;
    pending_matrices.push_back(mx);
    // tiny determinant: diagonal of one LSB each
    foreach (mx.m[k]) mx.m[k] = (k % 4 == 0) ? elem_t'(1) : '0;
    pending_matrices.push_back(mx);
    // scaled identities, positive and negative
    foreach (mx.m[k]) mx.m[k] = (k % 4 == 0) ? (one <<< 2) : '0;
    pending_matrices.push_back(mx);
    foreach (mx.m[k]) mx.m[k] = (k % 4 == 0) ? -(one >>> 1) : '0;
    pending_matrices.push_back(mx);
    // two equal rows, singular with nonzero content
    for (int k = 0; k < 3; k++) begin
      mx.m[k] = elem_t'($urandom);
      mx.m[k + 3] = mx.m[k];
      mx.m[k + 6] = elem_t'($urandom);
    end
    pending_matrices.push_back(mx);
    // all ones-pattern and alternating bits
    foreach (mx.m[k]) mx.m[k] = (k % 2) ? elem_t'(32'hAAAA_AAAA) : elem_t'(32'h5555_5555);
    pending_matrices.push_back(mx);
    foreach (mx.m[k]) mx.m[k] = elem_t'(-1);
    pending_matrices.push_back(mx);
    // permutation matrix, negative determinant
    foreach (mx.m[k]) mx.m[k] = (k == 1 || k == 3 || k == 8) ? one : '0;
    pending_matrices.push_back(mx);
    for (int n = 0; n < N_RANDOM; n++) begin
      foreach (mx.m[k]) mx.m[k] = random_elem();
      // now and then force a repeated row to hit the singular path
      if ($urandom_range(0, 15) == 0)
        for (int k = 0; k < 3; k++) mx.m[6 + k] = mx.m[k];
      pending_matrices.push_back(mx);
    end
  end

  // long hold-off on the result side while the sender keeps offering items
  initial begin
    wait (n_sent == 300);
    hold_off = 1'b1;
    repeat (3 * LATENCY) @(posedge clk);
    hold_off = 1'b0;
  end

  // driver: stay valid across accepts, idle gaps come in random bursts
  int drv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_inverses.push_back(invert_matrix(pending_matrices.pop_front()));
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        quiet = pending_matrices.size() < QUIET_LEN;
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_matrices.size() != 0 &&
                     (in_valid && !in_stall ? pending_matrices.size() > 0 : 1'b1)) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            drv_gap = $urandom_range(0, 3);
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            foreach (in_a[k]) in_a[k] <= pending_matrices[0].m[k];
          end
        end else begin
          in_valid <= 1'b0;
          if (pending_matrices.size() == 0) stimulus_done = 1'b1;
        end
      end
    end
  end

  // monitor and receiver stall
  int mon_gap = 0;
  always @(posedge clk) begin
    inverse_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          errors++;
          $display("result %0d arrived with nothing expected", n_checked);
        end else begin
          want = expected_inverses.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_b[k] !== want.inv[k])
              report_mismatch($sformatf("b%0d%0d", k / 3, k % 3), out_b[k], want.inv[k]);
          if (out_determinant !== want.det)
            report_mismatch("determinant", out_determinant, want.det);
          if (out_singular !== want.sing)
            report_mismatch("singular", elem_t'(out_singular), elem_t'(want.sing));
          if (want.sing) n_singular++;
          if (!want.sing && (want.det == 0 || want.inv[0] == elem_t'({1'b0, {31{1'b1}}})
                             || want.inv[0] == elem_t'({1'b1, {31{1'b0}}})))
            n_saturated++;
        end
        n_checked++;
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        mon_gap = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // reset, then wait for the drain
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && !in_valid);
    wait (expected_inverses.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    $display("checked %0d inverses: %0d singular, %0d with saturation or tiny determinant",
             n_checked, n_singular, n_saturated);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d inverses outstanding", expected_inverses.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
